FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/mpbr_pkg.sv
// Package with constants, types and helper functions of the mosaic block.
`default_nettype none

package mpbr_pkg;

   localparam int MAX_FRAME_WIDTH = 1024;
   localparam int HEIGHT_LIMIT    = 1024;
   localparam int BASE_BLOCK      = 160;

   localparam int PIXEL_W   = 32;
   localparam int ADDR_W    = $clog2(MAX_FRAME_WIDTH);
   localparam int COUNT_W   = 10;
   localparam int BLOCK_W   = 8;
   localparam int LEVEL_W   = 3;
   localparam int DIM_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MOSAIC_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 3'd0;
   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 11'd480;

   typedef struct packed {
      logic [LEVEL_W-1:0] mosaic_level;
      logic [DIM_W-1:0]   frame_width;
      logic [DIM_W-1:0]   frame_height;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] anchor_addr;
      logic              anchor_wr;
      logic              frame_end;
   } ctl_type;

   // Block edge length; a level that would shift the size to zero gives 1.
   function automatic logic [BLOCK_W-1:0] block_size(input logic [LEVEL_W-1:0] level);
      logic [BLOCK_W-1:0] size;
      size = BLOCK_W'(BASE_BLOCK >> level);
      if (size == '0) begin
         size = BLOCK_W'(1);
      end
      return size;
   endfunction

   // Forces a dimension into the range 1 to limit.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                   input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = DIM_W'(1);
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mpbr_counter.sv
// Position counters: column, block and band tracking, anchor address and frame end.
`default_nettype none

module mpbr_counter
   import mpbr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire cfg_type cfg,
   output ctl_type      ctl
);

   logic [COUNT_W-1:0] column_ff, column_in;
   logic [BLOCK_W-1:0] offset_ff, offset_in;
   logic [ADDR_W-1:0]  block_idx_ff, block_idx_in;
   logic [COUNT_W-1:0] row_ff, row_in;
   logic [BLOCK_W-1:0] band_row_ff, band_row_in;

   logic [BLOCK_W-1:0] blk;
   logic [DIM_W-1:0]   width;
   logic [DIM_W-1:0]   height;
   logic               column_last;
   logic               row_last;
   logic               offset_last;
   logic               band_last;

   always_comb begin
      blk    = block_size(cfg.mosaic_level);
      width  = clamp_dim(cfg.frame_width, DIM_W'(MAX_FRAME_WIDTH));
      height = clamp_dim(cfg.frame_height, DIM_W'(HEIGHT_LIMIT));

      // A counter left at or past a lowered limit wraps on its next step.
      column_last = (DIM_W'(column_ff) + DIM_W'(1)) >= width;
      row_last    = (DIM_W'(row_ff) + DIM_W'(1)) >= height;
      offset_last = ({1'b0, offset_ff} + 9'd1) >= {1'b0, blk};
      band_last   = ({1'b0, band_row_ff} + 9'd1) >= {1'b0, blk};
   end

   always_comb begin
      column_in    = column_ff;
      offset_in    = offset_ff;
      block_idx_in = block_idx_ff;
      row_in       = row_ff;
      band_row_in  = band_row_ff;
      if (column_last) begin
         column_in    = '0;
         offset_in    = '0;
         block_idx_in = '0;
         if (row_last) begin
            row_in      = '0;
            band_row_in = '0;
         end else begin
            row_in      = row_ff + COUNT_W'(1);
            band_row_in = band_last ? '0 : band_row_ff + BLOCK_W'(1);
         end
      end else begin
         column_in = column_ff + COUNT_W'(1);
         if (offset_last) begin
            offset_in    = '0;
            block_idx_in = block_idx_ff + ADDR_W'(1);
         end else begin
            offset_in = offset_ff + BLOCK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         offset_ff    <= '0;
         block_idx_ff <= '0;
         row_ff       <= '0;
         band_row_ff  <= '0;
      end else if (advance) begin
         column_ff    <= column_in;
         offset_ff    <= offset_in;
         block_idx_ff <= block_idx_in;
         row_ff       <= row_in;
         band_row_ff  <= band_row_in;
      end
   end

   always_comb begin
      ctl.anchor_addr = block_idx_ff;
      ctl.anchor_wr   = (band_row_ff == '0) && (offset_ff == '0);
      ctl.frame_end   = column_last && row_last;
   end

endmodule

`default_nettype wire

FILE: rtl/core/mpbr_anchor_ram.sv
// Anchor line store: one entry per block column, write-first with registered read.
`default_nettype none

module mpbr_anchor_ram
   import mpbr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire ctl_type            ctl,
   input  wire logic [PIXEL_W-1:0] wdata,
   output logic [PIXEL_W-1:0]      rdata
);

   logic [PIXEL_W-1:0] mem [MAX_FRAME_WIDTH];
   logic [PIXEL_W-1:0] rdata_ff;

   // On an anchor write the new pixel passes straight to the read register.
   always_ff @(posedge clock) begin
      if (enable) begin
         if (ctl.anchor_wr) begin
            mem[ctl.anchor_addr] <= wdata;
            rdata_ff             <= wdata;
         end else begin
            rdata_ff <= mem[ctl.anchor_addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pixel_mosaic_block_replicate_top.sv
// Top level of the mosaic pixelation filter: registers, pipeline and handshakes.
//
// Pixels enter on the req_ channel, one 32-bit word per pixel, bottom row
// first and left to right within a row. Each accepted word yields one word on
// the rsp_ channel: the pixel of its block's bottom-left corner, with
// rsp_frame_end set on the last pixel of the frame. A word is moved when
// valid is high and stall is low at a rising clock edge.
// A word passes the anchor store, then the output register. Throughput is one
// pixel per cycle while rsp_stall is low, set by the single-port anchor store
// that is written or read once per word. The two pipeline registers let a new
// word enter while a finished word waits on a stalled receiver; req_stall
// rises only once both are full. The csr_ port writes mosaic_level,
// frame_width and frame_height; the user must write it only while no word is
// in flight, which the block does not enforce. Reset (synchronous) empties
// the pipeline, restarts the position counters at the bottom-left corner and
// restores the register defaults (level 0, 640 by 480); the anchor store is
// not cleared, as every entry is written before it is read.
`default_nettype none

module pixel_mosaic_block_replicate_top
   import mpbr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [PIXEL_W-1:0]   req_pixel_value,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [PIXEL_W-1:0]        rsp_mosaic_pixel,
   output logic                      rsp_frame_end,

   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata
);

   cfg_type            cfg_ff;
   ctl_type            ctl;
   logic [PIXEL_W-1:0] anchor_pixel;

   logic               mid_valid_ff;
   logic               mid_end_ff;
   logic               out_valid_ff;
   logic               out_end_ff;
   logic [PIXEL_W-1:0] out_pixel_ff;

   logic               accept;
   logic               mid_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mosaic_level <= LEVEL_RESET;
         cfg_ff.frame_width  <= WIDTH_RESET;
         cfg_ff.frame_height <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MOSAIC_LEVEL: cfg_ff.mosaic_level <= csr_wdata[LEVEL_W-1:0];
            CSR_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_wdata;
            CSR_FRAME_HEIGHT: cfg_ff.frame_height <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mid_move  = mid_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall = mid_valid_ff && !mid_move;
      accept    = req_valid && !req_stall;
   end

   mpbr_counter u_counter (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cfg     (cfg_ff),
      .ctl     (ctl)
   );

   mpbr_anchor_ram u_anchor_ram (
      .clock  (clock),
      .enable (accept),
      .ctl    (ctl),
      .wdata  (req_pixel_value),
      .rdata  (anchor_pixel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mid_valid_ff <= 1'b1;
         end else if (mid_move) begin
            mid_valid_ff <= 1'b0;
         end
         if (mid_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_end_ff <= ctl.frame_end;
      end
      if (mid_move) begin
         out_pixel_ff <= anchor_pixel;
         out_end_ff   <= mid_end_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mosaic_pixel = out_pixel_ff;
   assign rsp_frame_end    = out_end_ff;

endmodule

`default_nettype wire

FILE: rtl/core/mpbr_checker.sv
// Port-level checker for the mosaic filter top level, with its bind statement.
`default_nettype none
`include "assert_macros.svh"

module mpbr_checker
   import mpbr_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [PIXEL_W-1:0] rsp_mosaic_pixel,
   input wire logic               rsp_frame_end
);

   // Reset empties the pipeline.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // An empty output register means the pipeline can always take a word.
   `ASSERT_IMPL(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // Acceptance of a word is followed, after the mid register, by a valid output.
   `ASSERT_IMPL(a_latency, clock, reset, req_valid && !req_stall, ##2 rsp_valid)

   // A stalled result word holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_mosaic_pixel) && $stable(rsp_frame_end))

endmodule

bind pixel_mosaic_block_replicate_top mpbr_checker u_mpbr_checker (.*);

`default_nettype wire
